// File: rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  // fixed field widths
  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // operation that every cell applies to its stored word
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT_HEAD,
    OP_WRITE,
    OP_CLOSE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   word;
  } cell_ctrl_t;

endpackage

// File: rtl/bounded_deque_with_indexed_removal.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed 32-bit words held in a row of
// cells, slot 0 at the head. Every command (push head, push tail, pop head,
// pop tail, remove at a 1-based position) answers with one word in the next
// cycle: the removed value, a status and the new count. Each cell works out
// its own shift from the command and the addressed slot, so the chain updates
// in the same cycle the command is accepted and a new command can be taken
// every cycle while the output is not stalled; the removed word is read out of
// the addressed cell through an or of all cell outputs. A result waiting on
// m_tready stalls the input only when the output register is still full.
// The stored words are not cleared at reset; only occupied slots are read.
module bounded_deque_with_indexed_removal #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // cmd[2:0], value[34:3], position[39:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // removed_value[31:0], status[33:32],
                                // element_count[38:34], zero[39]
);
  import bdq_pkg::*;

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] value;
  logic [POS_W-1:0]  position;

  logic              accept;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              full;
  logic              empty;
  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   cnt_x;
  logic [CMPW-1:0]   pos_m1;
  logic [CW-1:0]     cnt_m1;

  cell_ctrl_t        ctrl;
  logic [IW-1:0]     target;
  logic [ST_W-1:0]   st;
  logic              take;
  logic [DATA_W-1:0] rd_word;

  logic [DATA_W-1:0] out_word;
  logic [ST_W-1:0]   out_st;
  logic [CNT_W-1:0]  out_cnt;
  logic [CMPW-1:0]   cnt_next_x;

  // input word unpacking
  assign cmd      = s_tdata[2:0];
  assign value    = s_tdata[34:3];
  assign position = s_tdata[39:35];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full   = (count == FULL_CNT);
  assign empty  = (count == '0);
  assign pos_x  = CMPW'(position);
  assign cnt_x  = CMPW'(count);
  assign pos_m1 = pos_x - CMPW'(1);
  assign cnt_m1 = count - CW'(1);

  // command decode
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.word  = value;
    target     = '0;
    st         = ST_OK;
    take       = 1'b0;
    count_next = count;
    case (cmd)
      CMD_PUSH_HEAD: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctrl.op    = OP_INSERT_HEAD;
          count_next = count + CW'(1);
        end
      end
      CMD_PUSH_TAIL: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctrl.op    = OP_WRITE;
          target     = count[IW-1:0];
          count_next = count + CW'(1);
        end
      end
      CMD_POP_HEAD: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          ctrl.op    = OP_CLOSE;
          take       = 1'b1;
          count_next = cnt_m1;
        end
      end
      CMD_POP_TAIL: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          ctrl.op    = OP_CLOSE;
          target     = cnt_m1[IW-1:0];
          take       = 1'b1;
          count_next = cnt_m1;
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          st = ST_BADPOS;
        end else begin
          ctrl.op    = OP_CLOSE;
          target     = pos_m1[IW-1:0];
          take       = 1'b1;
          count_next = cnt_m1;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
    if (!accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  bdq_chain #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .target  (target),
    .rd_word (rd_word)
  );

  // element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // output register
  assign cnt_next_x = CMPW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= take ? rd_word : '0;
      out_st   <= st;
      out_cnt  <= cnt_next_x[CNT_W-1:0];
    end
  end

  assign m_tdata = {1'b0, out_cnt, out_st, out_word};

endmodule

// File: rtl/bdq_cell.sv
`timescale 1ns / 1ps

module bdq_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic                       clk,
  input  bdq_pkg::cell_ctrl_t        ctrl,
  input  logic [IW-1:0]              target,
  input  logic [bdq_pkg::DATA_W-1:0] from_prev,
  input  logic [bdq_pkg::DATA_W-1:0] from_next,
  output logic [bdq_pkg::DATA_W-1:0] data,
  output logic [bdq_pkg::DATA_W-1:0] sel_data
);
  import bdq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic hit;
  logic at_or_behind;
  logic [DATA_W-1:0] data_next;

  // position of this cell against the addressed slot
  assign hit          = (target == MY_IDX);
  assign at_or_behind = (target <= MY_IDX);

  // local shift decision
  always_comb begin
    data_next = data;
    case (ctrl.op)
      OP_INSERT_HEAD: data_next = from_prev;
      OP_WRITE:       if (hit) data_next = ctrl.word;
      OP_CLOSE:       if (at_or_behind) data_next = from_next;
      default:        data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // word offered to the read-out when this slot is addressed
  assign sel_data = hit ? data : '0;

endmodule

// File: rtl/bdq_chain.sv
`timescale 1ns / 1ps

module bdq_chain #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                       clk,
  input  bdq_pkg::cell_ctrl_t        ctrl,
  input  logic [IW-1:0]              target,
  output logic [bdq_pkg::DATA_W-1:0] rd_word
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] q   [DEPTH];
  logic [DATA_W-1:0] sel [DEPTH];

  // row of cells, slot 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = ctrl.word;
    end else begin : g_mid_p
      assign prev_w = q[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign next_w = q[i];
    end else begin : g_mid_n
      assign next_w = q[i+1];
    end

    bdq_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .target    (target),
      .from_prev (prev_w),
      .from_next (next_w),
      .data      (q[i]),
      .sel_data  (sel[i])
    );
  end

  // at most one cell is addressed, so an or of all offers picks its word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | sel[i];
    end
  end

endmodule

// File: verif/bounded_deque_with_indexed_removal_test.sv
`timescale 1ns / 1ps

module bounded_deque_with_indexed_removal_test;
  import bdq_pkg::*;

  localparam int DEPTH_WORDS = 16;
  localparam int RANDOM_PER_PHASE = 271;
  localparam int MAX_PRINTS = 40;

  // command codes the block leaves alone
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // burst flavours for the random part
  localparam int MODE_FILL    = 0;
  localparam int MODE_DRAIN   = 1;
  localparam int MODE_BALANCE = 2;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  count;
  } deque_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic [4:0]        reps;
    logic              typed;
    logic [DATA_W-1:0] exp_word;
    logic [ST_W-1:0]   exp_status;
    logic [CNT_W-1:0]  exp_count;
  } directed_row_t;

  localparam int NUM_ROWS = 24;

  // directed walk: empty errors, extremes, bad positions, spare codes, full store
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{CMD_POP_HEAD,    32'h0,        5'd0,  5'd1,  1'b1, 32'h0, ST_EMPTY,  5'd0},
    '{CMD_POP_TAIL,    32'h0,        5'd0,  5'd1,  1'b1, 32'h0, ST_EMPTY,  5'd0},
    '{CMD_REMOVE,      32'h0,        5'd0,  5'd1,  1'b1, 32'h0, ST_EMPTY,  5'd0},
    '{CMD_REMOVE,      32'h0,        5'd31, 5'd1,  1'b1, 32'h0, ST_EMPTY,  5'd0},
    '{CMD_SPARE_FIRST, 32'hdead_beef, 5'd1, 5'd1,  1'b1, 32'h0, ST_OK,     5'd0},
    '{CMD_PUSH_HEAD,   32'h7fff_ffff, 5'd0, 5'd1,  1'b1, 32'h0, ST_OK,     5'd1},
    '{CMD_PUSH_TAIL,   32'h8000_0000, 5'd0, 5'd1,  1'b1, 32'h0, ST_OK,     5'd2},
    '{CMD_REMOVE,      32'h0,        5'd0,  5'd1,  1'b1, 32'h0, ST_BADPOS, 5'd2},
    '{CMD_REMOVE,      32'h0,        5'd3,  5'd1,  1'b1, 32'h0, ST_BADPOS, 5'd2},
    '{CMD_REMOVE,      32'h0,        5'd31, 5'd1,  1'b1, 32'h0, ST_BADPOS, 5'd2},
    '{CMD_PUSH_TAIL,   32'hffff_ffff, 5'd0, 5'd1,  1'b1, 32'h0, ST_OK,     5'd3},
    '{CMD_PUSH_HEAD,   32'h0,        5'd0,  5'd1,  1'b1, 32'h0, ST_OK,     5'd4},
    '{CMD_SPARE_MID,   32'h1234_5678, 5'd2, 5'd1,  1'b1, 32'h0, ST_OK,     5'd4},
    '{CMD_REMOVE,      32'h0,        5'd2,  5'd1,  1'b0, 32'h0, ST_OK,     5'd0},
    '{CMD_POP_TAIL,    32'h0,        5'd0,  5'd1,  1'b0, 32'h0, ST_OK,     5'd0},
    '{CMD_POP_HEAD,    32'h0,        5'd0,  5'd1,  1'b0, 32'h0, ST_OK,     5'd0},
    '{CMD_PUSH_TAIL,   32'h5555_aaaa, 5'd0, 5'd15, 1'b0, 32'h0, ST_OK,     5'd0},
    '{CMD_PUSH_HEAD,   32'h1,        5'd0,  5'd1,  1'b1, 32'h0, ST_FULL,   5'd16},
    '{CMD_PUSH_TAIL,   32'h2,        5'd0,  5'd1,  1'b1, 32'h0, ST_FULL,   5'd16},
    '{CMD_REMOVE,      32'h0,        5'd17, 5'd1,  1'b1, 32'h0, ST_BADPOS, 5'd16},
    '{CMD_REMOVE,      32'h0,        5'd16, 5'd1,  1'b0, 32'h0, ST_OK,     5'd0},
    '{CMD_REMOVE,      32'h0,        5'd1,  5'd1,  1'b0, 32'h0, ST_OK,     5'd0},
    '{CMD_SPARE_LAST,  32'hffff_ffff, 5'd31, 5'd1, 1'b1, 32'h0, ST_OK,     5'd14},
    '{CMD_POP_TAIL,    32'h0,        5'd0,  5'd1,  1'b0, 32'h0, ST_OK,     5'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // cmd[2:0], value[34:3], position[39:35]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // removed_value[31:0], status[33:32],
                              // element_count[38:34], zero[39]

  int send_idle_pct = 23;
  int recv_idle_pct = 68;
  int mismatch_count = 0;

  // shadow copy of the stored words, head at the front
  logic [DATA_W-1:0] shadow_words[$];
  deque_result_t     pending_results[$];

  bounded_deque_with_indexed_removal #(
    .DEPTH(DEPTH_WORDS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  // apply one command to the shadow deque and return the answer it should give
  function automatic deque_result_t apply_deque_command(input logic [CMD_W-1:0] cmd,
                                                        input logic [DATA_W-1:0] value,
                                                        input logic [POS_W-1:0] pos);
    deque_result_t res;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH_HEAD: begin
        if (shadow_words.size() >= DEPTH_WORDS) res.status = ST_FULL;
        else shadow_words.push_front(value);
      end
      CMD_PUSH_TAIL: begin
        if (shadow_words.size() >= DEPTH_WORDS) res.status = ST_FULL;
        else shadow_words.push_back(value);
      end
      CMD_POP_HEAD: begin
        if (shadow_words.size() == 0) res.status = ST_EMPTY;
        else res.word = shadow_words.pop_front();
      end
      CMD_POP_TAIL: begin
        if (shadow_words.size() == 0) res.status = ST_EMPTY;
        else res.word = shadow_words.pop_back();
      end
      CMD_REMOVE: begin
        // emptiness wins over a bad position
        if (shadow_words.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (pos < 1 || pos > shadow_words.size()) begin
          res.status = ST_BADPOS;
        end else begin
          res.word = shadow_words[pos - 1];
          shadow_words.delete(pos - 1);
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(shadow_words.size());
    return res;
  endfunction

  // offer one word, optionally after a gap, and log its answer once taken
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                              input logic [POS_W-1:0] pos, input logic typed,
                              input deque_result_t typed_res);
    deque_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pos, value, cmd};
    do @(posedge clk); while (!s_tready);
    predicted = apply_deque_command(cmd, value, pos);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // hold off the sender until every answer is back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // pick a command that suits the burst, mostly well formed
  task automatic pick_random_command(input int mode, output logic [CMD_W-1:0] cmd,
                                     output logic [DATA_W-1:0] value,
                                     output logic [POS_W-1:0] pos);
    int push_pct;
    int r;
    push_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_BALANCE) ? 50 : 25;
    r = $urandom_range(99);
    value = $urandom;
    pos = POS_W'($urandom_range(31));
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: value = 32'h8000_0000;
        1: value = 32'h7fff_ffff;
        2: value = 32'hffff_ffff;
        default: value = 32'h0;
      endcase
    end
    if (r < 2) begin
      cmd = CMD_SPARE_FIRST + CMD_W'($urandom_range(2));
    end else if (r < 2 + push_pct) begin
      cmd = $urandom_range(1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
    end else begin
      case ($urandom_range(2))
        0: cmd = CMD_POP_HEAD;
        1: cmd = CMD_POP_TAIL;
        default: cmd = CMD_REMOVE;
      endcase
      // mostly a live position, now and then anything the field holds
      if (shadow_words.size() != 0 && $urandom_range(99) < 85) begin
        pos = POS_W'($urandom_range(shadow_words.size(), 1));
      end
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each answer word with the oldest prediction
  always @(posedge clk) begin : answer_check
    deque_result_t got;
    deque_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.word   = m_tdata[31:0];
      got.status = m_tdata[33:32];
      got.count  = m_tdata[38:34];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("answer word %h with nothing outstanding", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.word != want.word)
          report_mismatch($sformatf("removed value %h, wanted %h", got.word, want.word));
        if (got.status != want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.count != want.count)
          report_mismatch($sformatf("count %0d, wanted %0d", got.count, want.count));
      end
    end
  end

  // stimulus
  initial begin
    directed_row_t row;
    deque_result_t typed_res;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos;
    int items_left;
    int burst_mode;
    int burst_len;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      typed_res.word   = row.exp_word;
      typed_res.status = row.exp_status;
      typed_res.count  = row.exp_count;
      for (int k = 0; k < row.reps; k++) begin
        send_command(row.cmd, row.value + k, row.pos, row.typed, typed_res);
      end
    end
    wait_for_results();

    // three idle mixes: sender light, sender heavy, none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 23 : 0;
      items_left = RANDOM_PER_PHASE;
      while (items_left > 0) begin
        burst_mode = $urandom_range(2);
        burst_len = $urandom_range(24, 8);
        for (int k = 0; k < burst_len && items_left > 0; k++) begin
          pick_random_command(burst_mode, cmd, value, pos);
          send_command(cmd, value, pos, 1'b0, '0);
          items_left--;
        end
      end
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
